// ===== rtl/mtbl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtbl_pkg
// shared constants and codes for the map table bilinear lookup
// ----------------------------------------------------------------------------
package mtbl_pkg;

  localparam int SPEED_MAX = 32;
  localparam int LOAD_MAX  = 32;
  localparam int CELLS_MAX = 1024;

  localparam int SPD_AW  = $clog2(SPEED_MAX);
  localparam int LD_AW   = $clog2(LOAD_MAX);
  localparam int CELL_AW = $clog2(CELLS_MAX);

  // request kinds
  localparam logic [2:0] FN_WR_SPEED = 3'd0;
  localparam logic [2:0] FN_WR_LOAD  = 3'd1;
  localparam logic [2:0] FN_WR_CELL  = 3'd2;
  localparam logic [2:0] FN_LOOKUP   = 3'd3;
  localparam logic [2:0] FN_VALIDATE = 3'd4;

  // result status
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SPEED_LEN   = 3'd1;
  localparam logic [2:0] ST_LOAD_LEN    = 3'd2;
  localparam logic [2:0] ST_CELLS       = 3'd3;
  localparam logic [2:0] ST_SPEED_ORDER = 3'd4;
  localparam logic [2:0] ST_LOAD_ORDER  = 3'd5;
  localparam logic [2:0] ST_BAD_INDEX   = 3'd6;

  // register byte addresses
  localparam logic [2:0] ADDR_SPEED_LEN = 3'd0;
  localparam logic [2:0] ADDR_LOAD_LEN  = 3'd4;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ===== rtl/mtbl_div.sv =====
// ----------------------------------------------------------------------------
// mtbl_div
// bit-serial signed divider, quotient truncated toward zero, low 16 bits out
// ----------------------------------------------------------------------------
module mtbl_div import mtbl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [33:0] num,
  input  logic signed [16:0] den,
  output div_ctl_t           ctl,
  output logic        [15:0] quo
);

  logic [33:0] dvd;
  logic [17:0] rem;
  logic [16:0] dvs;
  logic [5:0]  cnt;
  logic        neg;
  logic        busy;
  logic        done;
  logic [17:0] trial;
  logic        qbit;

  assign trial = {rem[16:0], dvd[33]};
  assign qbit  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd34;
        dvd  <= num[33] ? 34'(-num) : 34'(num);
        dvs  <= den[16] ? 17'(-den) : 17'(den);
        neg  <= num[33] ^ den[16];
        rem  <= '0;
      end else if (busy) begin
        rem <= qbit ? 18'(trial - {1'b0, dvs}) : trial;
        dvd <= {dvd[32:0], qbit};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ctl.start = start;
  assign ctl.done  = done;
  assign quo       = neg ? 16'(-dvd[15:0]) : dvd[15:0];

endmodule

// ===== rtl/map_table_bilinear_lookup.sv =====
// ----------------------------------------------------------------------------
// map_table_bilinear_lookup
// 2d engine map with axis search and bilinear interpolation
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         request: s_tuser func, s_tdata index/value/queries
//  m_*       out        result: m_tdata lookup_result and status
//  apb       in/out     speed_axis_length at 0x0, load_axis_length at 0x4
//
//  the length of a lookup depends on the scanned axis points, the
//  one-bit-per-cycle divider and the single read port of each memory;
//  a step with equal bracketing points skips the divider
//  one request is in work at a time; the result register lets the next
//  request in while a result still waits for m_tready
//  rst is synchronous; the memories are not cleared, lengths reset to 1
// ----------------------------------------------------------------------------
module map_table_bilinear_lookup import mtbl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // entry_index, entry_value, speed_query, load_query
  input  logic [2:0]  s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // lookup_result, status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_CELL = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIVS = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  localparam logic [6:0]  SPD_LIM  = 7'(SPEED_MAX);
  localparam logic [6:0]  LD_LIM   = 7'(LOAD_MAX);
  localparam logic [12:0] CELL_LIM = 13'(CELLS_MAX);

  logic [2:0]  state;
  logic [5:0]  slen, llen;

  // request held for the duration of the work
  logic [2:0]  func;
  logic [9:0]  idx;
  logic [15:0] val, sq, lq;

  // memories
  logic [15:0] speed_axis [SPEED_MAX];
  logic [15:0] load_axis  [LOAD_MAX];
  logic [15:0] cell_store [CELLS_MAX];
  logic [15:0] sp_dout, ld_dout, cl_dout;
  logic        sp_rd, ld_rd, cl_rd;
  logic [CELL_AW-1:0] cl_raddr;

  // scan engine
  logic        ax;          // 0 speed axis, 1 load axis
  logic [5:0]  cnt, pidx;
  logic        pend;
  logic [15:0] prev;
  logic [5:0]  lo_i [2];
  logic [5:0]  hi_i [2];
  logic [15:0] lo_v [2];
  logic [15:0] hi_v [2];

  // corners and interpolation
  logic [2:0]  ccnt;
  logic [15:0] corner [4];
  logic [1:0]  k;
  logic [15:0] low_col, high_col;
  logic signed [33:0] num;
  logic signed [16:0] den;
  logic [15:0] res;
  logic [2:0]  status;
  logic        div_start;
  div_ctl_t    div_ctl;
  logic [15:0] quo;

  logic        cfg_wr;
  logic [2:0]  len_st;
  logic [11:0] len_prod;
  logic [5:0]  len_cur;
  logic [15:0] q_cur, a_cur;
  logic        last, brk;
  logic [15:0] op_lo_c, op_hi_c, op_q, op_lo_p, op_hi_p;
  logic [5:0]  crow, ccol;
  logic [11:0] cidx;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      slen <= 6'd1;
      llen <= 6'd1;
    end else if (cfg_wr) begin
      if (paddr == ADDR_SPEED_LEN) slen <= pwdata[5:0];
      if (paddr == ADDR_LOAD_LEN)  llen <= pwdata[5:0];
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_SPEED_LEN: prdata = {26'd0, slen};
      ADDR_LOAD_LEN:  prdata = {26'd0, llen};
      default:        prdata = '0;
    endcase
  end

  // length checks shared by lookup and validation
  assign len_prod = slen * llen;
  always_comb begin
    if (slen == 6'd0 || {1'b0, slen} > SPD_LIM)    len_st = ST_SPEED_LEN;
    else if (llen == 6'd0 || {1'b0, llen} > LD_LIM) len_st = ST_LOAD_LEN;
    else if ({1'b0, len_prod} > CELL_LIM)         len_st = ST_CELLS;
    else                                          len_st = ST_OK;
  end

  // --------------------------------------------------------------------------
  // memories: one write and one registered read each
  // --------------------------------------------------------------------------
  assign sp_rd = (state == S_SCAN) && !ax && (cnt < slen);
  assign ld_rd = (state == S_SCAN) &&  ax && (cnt < llen);
  assign cl_rd = (state == S_CELL) && (ccnt < 3'd4);

  always_ff @(posedge clk) begin
    if (state == S_EXEC && func == FN_WR_SPEED && idx < 10'(SPEED_MAX))
      speed_axis[idx[SPD_AW-1:0]] <= val;
    if (sp_rd) sp_dout <= speed_axis[cnt[SPD_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && func == FN_WR_LOAD && idx < 10'(LOAD_MAX))
      load_axis[idx[LD_AW-1:0]] <= val;
    if (ld_rd) ld_dout <= load_axis[cnt[LD_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && func == FN_WR_CELL)
      cell_store[idx[CELL_AW-1:0]] <= val;
    if (cl_rd) cl_dout <= cell_store[cl_raddr];
  end

  // corner order: low/low, low speed high load, high speed low load, high/high
  always_comb begin
    crow     = ccnt[0] ? hi_i[1] : lo_i[1];
    ccol     = ccnt[1] ? hi_i[0] : lo_i[0];
    cidx     = slen * crow + 12'(ccol);
    cl_raddr = cidx[CELL_AW-1:0];
  end

  // scan compare
  assign len_cur = ax ? llen : slen;
  assign q_cur   = ax ? lq : sq;
  assign a_cur   = ax ? ld_dout : sp_dout;
  assign last    = (pidx == len_cur - 6'd1);
  assign brk     = (a_cur >= q_cur);

  // interpolation operands per step
  always_comb begin
    case (k)
      2'd0: begin
        op_lo_c = corner[0]; op_hi_c = corner[1]; op_q = lq;
        op_lo_p = lo_v[1];   op_hi_p = hi_v[1];
      end
      2'd1: begin
        op_lo_c = corner[2]; op_hi_c = corner[3]; op_q = lq;
        op_lo_p = lo_v[1];   op_hi_p = hi_v[1];
      end
      default: begin
        op_lo_c = low_col;   op_hi_c = high_col;  op_q = sq;
        op_lo_p = lo_v[0];   op_hi_p = hi_v[0];
      end
    endcase
  end

  assign div_start = (state == S_DIVS) && (den != '0);

  mtbl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .ctl   (div_ctl),
    .quo   (quo)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
    end else begin
      // a taken result drops valid unless the next one is loaded right now
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func  <= s_tuser;
            idx   <= s_tdata[9:0];
            val   <= s_tdata[25:10];
            sq    <= s_tdata[41:26];
            lq    <= s_tdata[57:42];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res    <= '0;
          status <= ST_OK;
          ax     <= 1'b0;
          cnt    <= '0;
          pend   <= 1'b0;
          state  <= S_FIN;
          case (func)
            FN_WR_SPEED: if (idx >= 10'(SPEED_MAX)) status <= ST_BAD_INDEX;
            FN_WR_LOAD:  if (idx >= 10'(LOAD_MAX))  status <= ST_BAD_INDEX;
            FN_LOOKUP, FN_VALIDATE: begin
              status <= len_st;
              if (len_st == ST_OK) state <= S_SCAN;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          pend <= sp_rd || ld_rd;
          pidx <= cnt;
          cnt  <= cnt + 6'd1;
          if (pend) begin
            prev <= a_cur;
            if (func == FN_LOOKUP) begin
              if (a_cur <= q_cur || pidx == '0) begin
                lo_v[ax] <= a_cur;
                lo_i[ax] <= pidx;
              end
              if (brk || last) begin
                hi_v[ax] <= a_cur;
                hi_i[ax] <= pidx;
                cnt      <= '0;
                pend     <= 1'b0;
                ax       <= 1'b1;
                if (ax) begin
                  ccnt  <= '0;
                  state <= S_CELL;
                end
              end
            end else begin
              if (pidx != '0 && prev >= a_cur) begin
                status <= ax ? ST_LOAD_ORDER : ST_SPEED_ORDER;
                state  <= S_FIN;
              end else if (last) begin
                cnt  <= '0;
                pend <= 1'b0;
                ax   <= 1'b1;
                if (ax) state <= S_FIN;
              end
            end
          end
        end
        S_CELL: begin
          ccnt <= ccnt + 3'd1;
          if (ccnt != 3'd0) corner[ccnt[1:0] - 2'd1] <= cl_dout;
          if (ccnt == 3'd4) begin
            k     <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          num   <= 34'($signed({1'b0, op_hi_c}) - $signed({1'b0, op_lo_c}))
                 * 34'($signed({1'b0, op_q}) - $signed({1'b0, op_lo_p}));
          den   <= $signed({1'b0, op_hi_p}) - $signed({1'b0, op_lo_p});
          state <= S_DIVS;
        end
        S_DIVS: begin
          if (den == '0) begin
            case (k)
              2'd0:    low_col  <= op_lo_c;
              2'd1:    high_col <= op_lo_c;
              default: res      <= op_lo_c;
            endcase
            k     <= k + 2'd1;
            state <= (k == 2'd2) ? S_FIN : S_MUL;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_ctl.done) begin
            case (k)
              2'd0:    low_col  <= op_lo_c + quo;
              2'd1:    high_col <= op_lo_c + quo;
              default: res      <= op_lo_c + quo;
            endcase
            k     <= k + 2'd1;
            state <= (k == 2'd2) ? S_FIN : S_MUL;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, status, res};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/mtbl_checker.sv =====
// ----------------------------------------------------------------------------
// mtbl_checker
// port-level checks for the map table bilinear lookup
// ----------------------------------------------------------------------------
module mtbl_checker import mtbl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // an error status carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18:16] != ST_OK |-> m_tdata[15:0] == 16'd0)
    else $error("error result with nonzero value");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[18:16] != 3'd7 && m_tdata[23:19] == 5'd0)
    else $error("bad status code");

  // after a request is taken, s_tready is low in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken back to back");

endmodule

bind map_table_bilinear_lookup mtbl_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
